// ----- rtl/core/svgpi_pkg.sv -----
// ----------------------------------------------------------------------------
// svgpi_pkg
// Shared types, codes and fixed-point helpers of the SVG path command
// interpreter.
// ----------------------------------------------------------------------------
package svgpi_pkg;

  localparam int CoordW   = 32;
  localparam int XW       = CoordW + 3;
  localparam int InDataW  = 6 * CoordW;
  localparam int InUserW  = 5;
  localparam int OutDataW = 4 * CoordW;
  localparam int OutUserW = 4;
  localparam int QDepth   = 4;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [XW-1:0]     wide_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  typedef struct packed {
    wide_t x;
    wide_t y;
  } wpt_t;

  typedef enum logic [3:0] {
    OP_REPEAT  = 4'd0,
    OP_MOVE    = 4'd1,
    OP_LINE    = 4'd2,
    OP_HORIZ   = 4'd3,
    OP_VERT    = 4'd4,
    OP_CUBIC   = 4'd5,
    OP_SMOOTH  = 4'd6,
    OP_QUAD    = 4'd7,
    OP_SQUAD   = 4'd8,
    OP_CLOSE   = 4'd9,
    OP_TILDE   = 4'd10,
    OP_BEGIN   = 4'd11,
    OP_UNKNOWN = 4'd12
  } op_t;

  // The active command register holds the repeat code when no command is active.
  localparam op_t NoCmd = OP_REPEAT;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_MOVE  = 3'd1,
    KIND_LINE  = 3'd2,
    KIND_QUAD  = 3'd3,
    KIND_CLOSE = 3'd4
  } kind_t;

  typedef struct packed {
    op_t  op;
    logic rel;
    logic halt;
    logic is_begin;
    logic set_start;
    logic refl;
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    pt_t  a;
    pt_t  b;
    pt_t  e;
  } entry_t;

  typedef struct packed {
    logic  cub;
    logic  two;
    logic  halted;
    kind_t k0;
    kind_t k1;
    pt_t   c0;
    pt_t   e0;
    pt_t   e1;
    pt_t   p0;
    pt_t   p1;
    pt_t   p2;
    pt_t   p3;
  } job_t;

  typedef struct packed {
    job_t job;
    wpt_t j;
    wpt_t k;
    wpt_t l;
    wpt_t o;
    wpt_t p;
    wpt_t q;
    wpt_t h1;
    wpt_t h2;
    wpt_t h3;
    wpt_t h4;
  } pipe_t;

  typedef struct packed {
    logic  two;
    logic  halted;
    kind_t k0;
    kind_t k1;
    pt_t   c0;
    pt_t   e0;
    pt_t   c1;
    pt_t   e1;
  } rec_t;

  localparam coord_t CMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam coord_t CMin = {1'b1, {(CoordW-1){1'b0}}};

  function automatic wide_t wext(coord_t v);
    return {{(XW-CoordW){v[CoordW-1]}}, v};
  endfunction

  function automatic coord_t sat(wide_t v);
    if (v > wext(CMax)) begin
      return CMax;
    end else if (v < wext(CMin)) begin
      return CMin;
    end
    return v[CoordW-1:0];
  endfunction

  function automatic wide_t wavg(wide_t a, wide_t b);
    logic [XW:0] s;
    s = {a[XW-1], a} + {b[XW-1], b};
    return s[XW:1];
  endfunction

  function automatic wide_t whalf3(wide_t a, wide_t b);
    logic [XW+1:0] ae;
    logic [XW+1:0] be;
    logic [XW+1:0] s;
    ae = {{2{a[XW-1]}}, a};
    be = {{2{b[XW-1]}}, b};
    s  = (ae << 1) + ae - be;
    return s[XW:1];
  endfunction

  function automatic wpt_t pw(pt_t p);
    wpt_t r;
    r.x = wext(p.x);
    r.y = wext(p.y);
    return r;
  endfunction

  function automatic pt_t padd(pt_t a, pt_t o);
    pt_t r;
    r.x = sat(wext(a.x) + wext(o.x));
    r.y = sat(wext(a.y) + wext(o.y));
    return r;
  endfunction

  function automatic pt_t prefl(pt_t c, pt_t p);
    pt_t r;
    r.x = sat((wext(c.x) <<< 1) - wext(p.x));
    r.y = sat((wext(c.y) <<< 1) - wext(p.y));
    return r;
  endfunction

  function automatic wpt_t pavg(wpt_t a, wpt_t b);
    wpt_t r;
    r.x = wavg(a.x, b.x);
    r.y = wavg(a.y, b.y);
    return r;
  endfunction

  function automatic wpt_t phalf3(wpt_t a, wpt_t b);
    wpt_t r;
    r.x = whalf3(a.x, b.x);
    r.y = whalf3(a.y, b.y);
    return r;
  endfunction

  function automatic pt_t psat(wpt_t a);
    pt_t r;
    r.x = sat(a.x);
    r.y = sat(a.y);
    return r;
  endfunction

endpackage

// ----- rtl/core/svg_path_command_interpreter.sv -----
// ----------------------------------------------------------------------------
// svg_path_command_interpreter
// Interprets parsed SVG path commands and emits move, line, quadratic and
// close segments; cubics are split into two quadratics.
// ----------------------------------------------------------------------------
// Each request on the in_ channel is one path command: op and rel in in_tuser,
// three Q16.16 points in in_tdata. The out_ channel returns one or two
// segments per command; out_tlast marks the final one, and a halted
// interpreter answers every command except begin path with one empty segment
// flagged halted. A begin-path command clears all path state and returns
// nothing.
// A command is classified on acceptance and waits in a short queue until the
// execution stage applies it to the path state, one command per cycle while
// the pipeline advances. A five-stage subdivision pipeline and an output
// register follow. The block takes one command per cycle while the queue is
// not full; cubics and tilde commands occupy the output register for one
// segment after the other, and the pipeline holds until the last is taken.
// Reset clears the queue, the pipeline and all path state. When the receiver
// holds out_tready low, the whole pipeline holds in place, the queue fills,
// and in_tready drops once the queue is full.
// ----------------------------------------------------------------------------
module svg_path_command_interpreter #(
  parameter int QDEPTH = svgpi_pkg::QDepth
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // ax, ay, bx, by, ex, ey from the lowest bit up
  input  logic [svgpi_pkg::InDataW-1:0]   in_tdata,
  // op, rel from the lowest bit up
  input  logic [svgpi_pkg::InUserW-1:0]   in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // ctl_x, ctl_y, end_x, end_y from the lowest bit up
  output logic [svgpi_pkg::OutDataW-1:0]  out_tdata,
  // kind, halted from the lowest bit up
  output logic [svgpi_pkg::OutUserW-1:0]  out_tuser,
  output logic                            out_tlast
);

  logic              push, full, pop, empty, adv, job_valid;
  svgpi_pkg::entry_t push_data, head;
  svgpi_pkg::job_t   job;

  svgpi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  svgpi_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_data),
    .full  (full),
    .pop   (pop),
    .rdata (head),
    .empty (empty)
  );

  svgpi_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .adv       (adv),
    .job_valid (job_valid),
    .job       (job)
  );

  svgpi_split u_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job        (job),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- rtl/core/svgpi_front.sv -----
// ----------------------------------------------------------------------------
// svgpi_front
// Accepts command requests, resolves repeats and the halt condition, and
// tags each command for the execution side.
// ----------------------------------------------------------------------------
module svgpi_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [svgpi_pkg::InDataW-1:0]     in_tdata,
  input  logic [svgpi_pkg::InUserW-1:0]     in_tuser,
  output logic                              push,
  output svgpi_pkg::entry_t                 push_data,
  input  logic                              full
);

  svgpi_pkg::op_t active_r, active_nxt;
  svgpi_pkg::op_t prior_r, prior_nxt;
  logic           rel_mode_r, rel_mode_nxt;
  logic           stopped_r, stopped_nxt;

  logic           acc;
  logic [3:0]     op_in;
  logic           rel_in;
  svgpi_pkg::cmd_t cmd;
  svgpi_pkg::op_t new_act;

  localparam int W = svgpi_pkg::CoordW;

  assign op_in     = in_tuser[3:0];
  assign rel_in    = in_tuser[4];
  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;
  assign push      = acc;

  always_comb begin
    cmd           = '0;
    cmd.op        = svgpi_pkg::op_t'(op_in);
    cmd.rel       = rel_in;
    active_nxt    = active_r;
    prior_nxt     = prior_r;
    rel_mode_nxt  = rel_mode_r;
    stopped_nxt   = stopped_r;
    new_act       = active_r;
    if (op_in == svgpi_pkg::OP_BEGIN) begin
      cmd.is_begin = 1'b1;
      active_nxt   = svgpi_pkg::NoCmd;
      prior_nxt    = svgpi_pkg::NoCmd;
      rel_mode_nxt = 1'b0;
      stopped_nxt  = 1'b0;
    end else begin
      if (stopped_r) begin
        cmd.halt = 1'b1;
      end else if (op_in == svgpi_pkg::OP_REPEAT) begin
        if (active_r == svgpi_pkg::NoCmd) begin
          cmd.halt = 1'b1;
        end else begin
          cmd.op  = active_r;
          cmd.rel = rel_mode_r;
        end
      end else if (op_in >= svgpi_pkg::OP_UNKNOWN) begin
        cmd.halt = 1'b1;
      end else begin
        rel_mode_nxt = rel_in;
      end
      stopped_nxt = stopped_r || cmd.halt;
      if (!cmd.halt) begin
        case (cmd.op) inside
          svgpi_pkg::OP_MOVE, svgpi_pkg::OP_LINE: new_act = svgpi_pkg::OP_LINE;
          svgpi_pkg::OP_CLOSE:                    new_act = svgpi_pkg::NoCmd;
          default:                                new_act = cmd.op;
        endcase
        active_nxt    = new_act;
        prior_nxt     = new_act;
        cmd.set_start = (prior_r == svgpi_pkg::NoCmd);
        cmd.refl      = ((cmd.op == svgpi_pkg::OP_SMOOTH) &&
                         ((prior_r == svgpi_pkg::OP_CUBIC) ||
                          (prior_r == svgpi_pkg::OP_SMOOTH))) ||
                        ((cmd.op == svgpi_pkg::OP_SQUAD) &&
                         ((prior_r == svgpi_pkg::OP_QUAD) ||
                          (prior_r == svgpi_pkg::OP_SQUAD)));
      end
    end
  end

  always_comb begin
    push_data     = '0;
    push_data.cmd = cmd;
    push_data.a.x = in_tdata[W-1:0];
    push_data.a.y = in_tdata[2*W-1:W];
    push_data.b.x = in_tdata[3*W-1:2*W];
    push_data.b.y = in_tdata[4*W-1:3*W];
    push_data.e.x = in_tdata[5*W-1:4*W];
    push_data.e.y = in_tdata[6*W-1:5*W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= svgpi_pkg::NoCmd;
      prior_r    <= svgpi_pkg::NoCmd;
      rel_mode_r <= 1'b0;
      stopped_r  <= 1'b0;
    end else if (acc) begin
      active_r   <= active_nxt;
      prior_r    <= prior_nxt;
      rel_mode_r <= rel_mode_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

endmodule

// ----- rtl/core/svgpi_fifo.sv -----
// ----------------------------------------------------------------------------
// svgpi_fifo
// Short command queue between the front and the execution side.
// ----------------------------------------------------------------------------
module svgpi_fifo #(
  parameter int DEPTH = svgpi_pkg::QDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  svgpi_pkg::entry_t wdata,
  output logic              full,
  input  logic              pop,
  output svgpi_pkg::entry_t rdata,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  svgpi_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     rp_r, rp_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end

endmodule

// ----- rtl/core/svgpi_exec.sv -----
// ----------------------------------------------------------------------------
// svgpi_exec
// Applies one command a cycle to the path state while the subdivision pipeline
// advances, and hands it the segment job with the cubic control polygon.
// ----------------------------------------------------------------------------
module svgpi_exec (
  input  logic              clk,
  input  logic              rst_n,
  input  svgpi_pkg::entry_t head,
  input  logic              empty,
  output logic              pop,
  input  logic              adv,
  output logic              job_valid,
  output svgpi_pkg::job_t   job
);

  svgpi_pkg::pt_t cur_r, cur_nxt;
  svgpi_pkg::pt_t start_r, start_nxt;
  svgpi_pkg::pt_t pctl_r, pctl_nxt;
  svgpi_pkg::pt_t emit_r, emit_nxt;

  svgpi_pkg::cmd_t cmd;
  svgpi_pkg::pt_t  org, av, bv, ev, rf;
  svgpi_pkg::coord_t vy;

  assign cmd       = head.cmd;
  assign job_valid = !empty && !cmd.is_begin;
  assign pop       = !empty && (cmd.is_begin || adv);

  always_comb begin
    org = cmd.rel ? cur_r : '0;
    av  = svgpi_pkg::padd(head.a, org);
    bv  = svgpi_pkg::padd(head.b, org);
    ev  = svgpi_pkg::padd(head.e, org);
    vy  = svgpi_pkg::sat(svgpi_pkg::wext(head.a.x) + svgpi_pkg::wext(org.y));
    rf  = cmd.refl ? svgpi_pkg::prefl(cur_r, pctl_r) : cur_r;
  end

  always_comb begin
    job        = '0;
    job.halted = cmd.halt;
    cur_nxt    = cur_r;
    pctl_nxt   = pctl_r;
    emit_nxt   = emit_r;
    if (!cmd.halt) begin
      unique case (cmd.op) inside
        svgpi_pkg::OP_MOVE, svgpi_pkg::OP_LINE: begin
          job.k0   = (cmd.op == svgpi_pkg::OP_MOVE) ? svgpi_pkg::KIND_MOVE
                                                    : svgpi_pkg::KIND_LINE;
          job.e0   = av;
          cur_nxt  = av;
          emit_nxt = av;
        end
        svgpi_pkg::OP_HORIZ: begin
          job.k0     = svgpi_pkg::KIND_LINE;
          job.e0.x   = av.x;
          job.e0.y   = cur_r.y;
          cur_nxt.x  = av.x;
          emit_nxt.x = av.x;
          emit_nxt.y = cur_r.y;
        end
        svgpi_pkg::OP_VERT: begin
          job.k0     = svgpi_pkg::KIND_LINE;
          job.e0.x   = cur_r.x;
          job.e0.y   = vy;
          cur_nxt.y  = vy;
          emit_nxt.x = cur_r.x;
          emit_nxt.y = vy;
        end
        svgpi_pkg::OP_CUBIC, svgpi_pkg::OP_SMOOTH: begin
          job.cub = 1'b1;
          job.two = 1'b1;
          job.k0  = svgpi_pkg::KIND_QUAD;
          job.k1  = svgpi_pkg::KIND_QUAD;
          job.p0  = emit_r;
          if (cmd.op == svgpi_pkg::OP_CUBIC) begin
            job.p1 = av;
            job.p2 = bv;
            job.p3 = ev;
          end else begin
            job.p1 = rf;
            job.p2 = av;
            job.p3 = bv;
          end
          job.e1   = job.p3;
          pctl_nxt = job.p2;
          cur_nxt  = job.p3;
          emit_nxt = job.p3;
        end
        svgpi_pkg::OP_QUAD, svgpi_pkg::OP_SQUAD: begin
          job.k0 = svgpi_pkg::KIND_QUAD;
          if (cmd.op == svgpi_pkg::OP_QUAD) begin
            job.c0 = av;
            job.e0 = bv;
          end else begin
            job.c0 = rf;
            job.e0 = av;
          end
          pctl_nxt = job.c0;
          cur_nxt  = job.e0;
          emit_nxt = job.e0;
        end
        svgpi_pkg::OP_CLOSE: begin
          job.k0   = svgpi_pkg::KIND_CLOSE;
          job.e0   = start_r;
          cur_nxt  = start_r;
          emit_nxt = start_r;
        end
        svgpi_pkg::OP_TILDE: begin
          job.two  = 1'b1;
          job.k0   = svgpi_pkg::KIND_MOVE;
          job.e0   = head.a;
          job.k1   = svgpi_pkg::KIND_LINE;
          job.e1   = head.b;
          emit_nxt = head.b;
        end
        default: begin
          job.k0 = svgpi_pkg::KIND_NONE;
        end
      endcase
    end
    start_nxt = cmd.set_start ? cur_nxt : start_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      start_r <= '0;
      pctl_r  <= '0;
      emit_r  <= '0;
    end else if (pop) begin
      if (cmd.is_begin) begin
        cur_r   <= '0;
        start_r <= '0;
        pctl_r  <= '0;
        emit_r  <= '0;
      end else begin
        cur_r   <= cur_nxt;
        start_r <= start_nxt;
        pctl_r  <= pctl_nxt;
        emit_r  <= emit_nxt;
      end
    end
  end

endmodule

// ----- rtl/core/svgpi_split.sv -----
// ----------------------------------------------------------------------------
// svgpi_split
// Five-stage midpoint subdivision pipeline that turns a cubic into two
// quadratics, followed by the output register that hands out results.
// ----------------------------------------------------------------------------
module svgpi_split (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            job_valid,
  input  svgpi_pkg::job_t                 job,
  output logic                            adv,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [svgpi_pkg::OutDataW-1:0]  out_tdata,
  output logic [svgpi_pkg::OutUserW-1:0]  out_tuser,
  output logic                            out_tlast
);

  localparam int NS = 5;

  svgpi_pkg::pipe_t st_r [NS];
  logic [NS-1:0]    sv_r;
  svgpi_pkg::rec_t  rec_r, rec_nxt;
  logic             ov_r;
  logic             idx_r;

  svgpi_pkg::pipe_t s0, s1, s2, s3, s4;
  logic             at_last;
  svgpi_pkg::kind_t kind;
  svgpi_pkg::pt_t   ctl, endp;

  assign at_last = idx_r || !rec_r.two;
  assign adv     = !ov_r || (out_tready && at_last);

  always_comb begin
    s0     = '0;
    s0.job = job;

    s1   = st_r[0];
    s1.j = svgpi_pkg::pavg(svgpi_pkg::pw(s1.job.p1), svgpi_pkg::pw(s1.job.p0));
    s1.k = svgpi_pkg::pavg(svgpi_pkg::pw(s1.job.p1), svgpi_pkg::pw(s1.job.p2));
    s1.l = svgpi_pkg::pavg(svgpi_pkg::pw(s1.job.p2), svgpi_pkg::pw(s1.job.p3));

    s2    = st_r[1];
    s2.o  = svgpi_pkg::pavg(s2.j, s2.k);
    s2.p  = svgpi_pkg::pavg(s2.k, s2.l);
    s2.h1 = svgpi_pkg::phalf3(s2.j, svgpi_pkg::pw(s2.job.p0));
    s2.h4 = svgpi_pkg::phalf3(s2.l, svgpi_pkg::pw(s2.job.p3));

    s3   = st_r[2];
    s3.q = svgpi_pkg::pavg(s3.o, s3.p);

    s4    = st_r[3];
    s4.h2 = svgpi_pkg::phalf3(s4.o, s4.q);
    s4.h3 = svgpi_pkg::phalf3(s4.p, s4.q);
  end

  always_comb begin
    rec_nxt        = '0;
    rec_nxt.two    = st_r[4].job.two;
    rec_nxt.halted = st_r[4].job.halted;
    rec_nxt.k0     = st_r[4].job.k0;
    rec_nxt.k1     = st_r[4].job.k1;
    rec_nxt.e1     = st_r[4].job.e1;
    if (st_r[4].job.cub) begin
      rec_nxt.c0 = svgpi_pkg::psat(svgpi_pkg::pavg(st_r[4].h1, st_r[4].h2));
      rec_nxt.e0 = svgpi_pkg::psat(st_r[4].q);
      rec_nxt.c1 = svgpi_pkg::psat(svgpi_pkg::pavg(st_r[4].h3, st_r[4].h4));
    end else begin
      rec_nxt.c0 = st_r[4].job.c0;
      rec_nxt.e0 = st_r[4].job.e0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r  <= '0;
      ov_r  <= 1'b0;
      idx_r <= 1'b0;
    end else if (adv) begin
      sv_r  <= {sv_r[NS-2:0], job_valid};
      ov_r  <= sv_r[NS-1];
      idx_r <= 1'b0;
    end else if (out_tready) begin
      idx_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= s0;
      st_r[1] <= s1;
      st_r[2] <= s2;
      st_r[3] <= s3;
      st_r[4] <= s4;
      rec_r   <= rec_nxt;
    end
  end

  always_comb begin
    kind = idx_r ? rec_r.k1 : rec_r.k0;
    ctl  = idx_r ? rec_r.c1 : rec_r.c0;
    endp = idx_r ? rec_r.e1 : rec_r.e0;
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = at_last;
  assign out_tuser  = {rec_r.halted, kind};
  assign out_tdata  = {endp.y, endp.x, ctl.y, ctl.x};

endmodule
